FILE: src/srtf_pkg.sv
`timescale 1ns / 1ps
package srtf_pkg;

  localparam int SLOT_W    = 21;
  localparam int ID_W      = 4;
  localparam int IN_TIME_W = 16;
  localparam int PCNT_W    = 5;

  localparam logic [SLOT_W-1:0] CLOCK_MAX = {SLOT_W{1'b1}};

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  typedef struct packed {
    logic load;        // capture a load transaction
    logic tick_start;  // clear the scan state for a tick
    logic scan_rd;     // issue one table read
    logic update;      // commit the pick and stage the tick result
    logic emit;        // move the staged result into the output register
  } ctl_cmd_t;

  typedef struct packed {
    logic scan_more;
  } dp_stat_t;

endpackage

FILE: src/srtf_if.sv
`timescale 1ns / 1ps
interface srtf_in_if
  import srtf_pkg::*;
  ();
  logic                 valid;
  logic                 ready;
  logic                 func;
  logic [IN_TIME_W-1:0] arrival_time;
  logic [IN_TIME_W-1:0] burst_time;

  modport source (output valid, func, arrival_time, burst_time, input ready);
  modport sink   (input valid, func, arrival_time, burst_time, output ready);
endinterface

interface srtf_out_if
  import srtf_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [SLOT_W-1:0] slot_time;
  logic [ID_W-1:0]   running_id;
  logic              idle;
  logic              segment_start;
  logic              finished;
  logic [SLOT_W-1:0] turnaround;
  logic [SLOT_W-1:0] waiting;
  logic              all_done;
  logic              load_error;

  modport source (output valid, slot_time, running_id, idle, segment_start, finished,
                  turnaround, waiting, all_done, load_error, input ready);
  modport sink   (input valid, slot_time, running_id, idle, segment_start, finished,
                  turnaround, waiting, all_done, load_error, output ready);
endinterface

FILE: src/srtf_ctrl.sv
`timescale 1ns / 1ps
module srtf_ctrl
  import srtf_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     in_func_i,
  output logic     in_ready_o,
  input  logic     out_ready_i,
  output logic     out_valid_o,
  input  dp_stat_t stat_i,
  output ctl_cmd_t cmd_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_UPD  = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       in_fire;
  logic       out_free;

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          if (in_func_i == FUNC_TICK) begin
            cmd_o.tick_start = 1'b1;
            state_d          = S_SCAN;
          end else begin
            cmd_o.load = 1'b1;
            state_d    = S_EMIT;
          end
        end
      end
      S_SCAN: begin
        // last read data is compared in the cycle scan_more drops
        if (stat_i.scan_more) begin
          cmd_o.scan_rd = 1'b1;
        end else begin
          state_d = S_UPD;
        end
      end
      S_UPD: begin
        cmd_o.update = 1'b1;
        state_d      = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          cmd_o.emit  = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

FILE: src/srtf_dp.sv
`timescale 1ns / 1ps
module srtf_dp
  import srtf_pkg::*;
#(
  parameter int MAX_PROCS = 16,
  parameter int TIME_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [PCNT_W-1:0]    cfg_data_i,
  input  logic [IN_TIME_W-1:0] arrival_time_i,
  input  logic [IN_TIME_W-1:0] burst_time_i,
  input  ctl_cmd_t             cmd_i,
  output dp_stat_t             stat_o,
  output logic [SLOT_W-1:0]    slot_time_o,
  output logic [ID_W-1:0]      running_id_o,
  output logic                 idle_o,
  output logic                 segment_start_o,
  output logic                 finished_o,
  output logic [SLOT_W-1:0]    turnaround_o,
  output logic [SLOT_W-1:0]    waiting_o,
  output logic                 all_done_o,
  output logic                 load_error_o
);

  localparam int IDX_W   = $clog2(MAX_PROCS);
  localparam int CNT_MIN = $clog2(MAX_PROCS + 1);
  localparam int CNT_W   = (CNT_MIN > PCNT_W) ? CNT_MIN : PCNT_W;
  localparam int CW      = (TIME_BITS > SLOT_W) ? TIME_BITS : SLOT_W;
  localparam int WORD_W  = 3 * TIME_BITS;

  // table word: {arrival, burst, remaining}
  logic [WORD_W-1:0] mem [MAX_PROCS];
  logic              mem_we;
  logic [IDX_W-1:0]  mem_wa;
  logic [WORD_W-1:0] mem_wd;
  logic [WORD_W-1:0] rd_data_q;
  logic [IDX_W-1:0]  rd_idx_q;
  logic              rd_vld_q;

  logic [PCNT_W-1:0] pcount_q;
  logic [CNT_W-1:0]  loaded_q;
  logic [SLOT_W-1:0] cur_time_q;
  logic [IDX_W-1:0]  prev_id_q;
  logic              prev_run_q;

  logic [CNT_W-1:0]  scan_idx_q;
  logic              have_q, pending_q, two_q;
  logic [IDX_W-1:0]  best_idx_q;
  logic [TIME_BITS-1:0] best_arr_q, best_bur_q, best_rem_q;

  // staged result
  logic [SLOT_W-1:0]    st_slot_q;
  logic [ID_W-1:0]      st_id_q;
  logic                 st_idle_q, st_seg_q, st_fin_q, st_done_q, st_lerr_q;
  logic [SLOT_W-1:0]    st_tat_q;
  logic [TIME_BITS-1:0] st_bur_q;

  logic [CNT_W-1:0]     pc_ext, eff_cnt, active;
  logic                 full;
  logic [TIME_BITS-1:0] ld_arr, ld_bur;
  logic                 ld_ok;
  logic [TIME_BITS-1:0] r_arr, r_bur, r_rem;
  logic                 r_arrived, r_better;
  logic [SLOT_W-1:0]    next_time;
  logic [TIME_BITS-1:0] new_rem;
  logic                 fin_now;
  logic [CW-1:0]        tat_ext, bur_ext;
  logic [SLOT_W-1:0]    wait_val;

  assign pc_ext  = CNT_W'(pcount_q);
  assign eff_cnt = (pc_ext > CNT_W'(MAX_PROCS)) ? CNT_W'(MAX_PROCS) : pc_ext;
  assign active  = (loaded_q < eff_cnt) ? loaded_q : eff_cnt;
  assign full    = (loaded_q >= eff_cnt);

  assign ld_arr = TIME_BITS'(arrival_time_i);
  assign ld_bur = TIME_BITS'(burst_time_i);
  assign ld_ok  = !full && (ld_bur != '0);

  assign stat_o.scan_more = (scan_idx_q < active);

  assign {r_arr, r_bur, r_rem} = rd_data_q;
  assign r_arrived = (CW'(r_arr) <= CW'(cur_time_q));
  // ties: earlier arrival, then lower index by scan order
  assign r_better  = !have_q || (r_rem < best_rem_q) ||
                     ((r_rem == best_rem_q) && (r_arr < best_arr_q));

  assign next_time = (cur_time_q == CLOCK_MAX) ? cur_time_q : cur_time_q + 1'b1;
  assign new_rem   = best_rem_q - 1'b1;
  assign fin_now   = (new_rem == '0);

  assign tat_ext  = CW'(st_tat_q);
  assign bur_ext  = CW'(st_bur_q);
  assign wait_val = (tat_ext >= bur_ext) ? SLOT_W'(tat_ext - bur_ext) : '0;

  always_comb begin
    mem_we = 1'b0;
    mem_wa = best_idx_q;
    mem_wd = {best_arr_q, best_bur_q, new_rem};
    if (cmd_i.load && ld_ok) begin
      mem_we = 1'b1;
      mem_wa = loaded_q[IDX_W-1:0];
      mem_wd = {ld_arr, ld_bur, ld_bur};
    end else if (cmd_i.update && have_q) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (cmd_i.scan_rd) begin
      rd_data_q <= mem[scan_idx_q[IDX_W-1:0]];
      rd_idx_q  <= scan_idx_q[IDX_W-1:0];
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pcount_q   <= PCNT_W'(1);
      loaded_q   <= '0;
      cur_time_q <= '0;
      prev_id_q  <= '0;
      prev_run_q <= 1'b0;
      scan_idx_q <= '0;
      rd_vld_q   <= 1'b0;
      have_q     <= 1'b0;
      pending_q  <= 1'b0;
      two_q      <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        pcount_q <= cfg_data_i;
      end
      if (cmd_i.load && ld_ok) begin
        loaded_q <= loaded_q + 1'b1;
      end
      rd_vld_q <= cmd_i.scan_rd;
      if (cmd_i.tick_start) begin
        scan_idx_q <= '0;
        have_q     <= 1'b0;
        pending_q  <= 1'b0;
        two_q      <= 1'b0;
      end else begin
        if (cmd_i.scan_rd) begin
          scan_idx_q <= scan_idx_q + 1'b1;
        end
        if (rd_vld_q && (r_rem != '0)) begin
          pending_q <= 1'b1;
          two_q     <= two_q || pending_q;
          if (r_arrived && r_better) begin
            have_q <= 1'b1;
          end
        end
      end
      if (cmd_i.update && (pending_q || !full)) begin
        cur_time_q <= next_time;
        prev_run_q <= have_q;
        if (have_q) begin
          prev_id_q <= best_idx_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_vld_q && (r_rem != '0) && r_arrived && r_better) begin
      best_idx_q <= rd_idx_q;
      best_arr_q <= r_arr;
      best_bur_q <= r_bur;
      best_rem_q <= r_rem;
    end
  end

  // result staging
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      st_slot_q <= '0;
      st_id_q   <= '0;
      st_idle_q <= 1'b0;
      st_seg_q  <= 1'b0;
      st_fin_q  <= 1'b0;
      st_tat_q  <= '0;
      st_bur_q  <= '0;
      st_done_q <= 1'b0;
      st_lerr_q <= !ld_ok;
    end else if (cmd_i.update) begin
      st_slot_q <= cur_time_q;
      st_lerr_q <= 1'b0;
      st_tat_q  <= '0;
      st_bur_q  <= best_bur_q;
      st_fin_q  <= 1'b0;
      st_id_q   <= '0;
      if (!pending_q && full) begin
        // everything done: no state change
        st_idle_q <= 1'b1;
        st_seg_q  <= 1'b0;
        st_done_q <= 1'b1;
      end else if (have_q) begin
        st_id_q   <= ID_W'(best_idx_q);
        st_idle_q <= 1'b0;
        st_seg_q  <= !prev_run_q || (prev_id_q != best_idx_q);
        st_fin_q  <= fin_now;
        if (fin_now) begin
          st_tat_q <= next_time - SLOT_W'(best_arr_q);
        end
        st_done_q <= full && !two_q && fin_now;
      end else begin
        st_idle_q <= 1'b1;
        st_seg_q  <= prev_run_q;
        st_done_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      slot_time_o     <= st_slot_q;
      running_id_o    <= st_id_q;
      idle_o          <= st_idle_q;
      segment_start_o <= st_seg_q;
      finished_o      <= st_fin_q;
      turnaround_o    <= st_tat_q;
      waiting_o       <= st_fin_q ? wait_val : '0;
      all_done_o      <= st_done_q;
      load_error_o    <= st_lerr_q;
    end
  end

endmodule

FILE: src/srtf_scheduler_core.sv
`timescale 1ns / 1ps
// Preemptive shortest-remaining-time-first scheduler. A load transaction
// (func = 0) appends one process to the table; its result passes through
// the emit state into the output register, and the next transaction is
// taken back in the idle state. A tick transaction (func = 1) scans the
// active table entries one per cycle through the single read port of the
// process table, then compares the last entry read and commits the pick in
// the update state. Its result then passes through the emit state into the
// output register, and the next transaction is taken back in the idle
// state. A result that waits in the output register stalls the next
// result, and with it the input. The user must write process_count
// through cfg_we_i/cfg_data_i only while idle; the block does not enforce it.
// A new transaction is taken while the previous result still waits in the
// output register.
module srtf_scheduler_core
  import srtf_pkg::*;
#(
  parameter int MAX_PROCS = 16,
  parameter int TIME_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [PCNT_W-1:0] cfg_data_i,
  srtf_in_if.sink           in_i,
  srtf_out_if.source        out_o
);

  ctl_cmd_t cmd;
  dp_stat_t stat;

  srtf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_func_i   (in_i.func),
    .in_ready_o  (in_i.ready),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  srtf_dp #(
    .MAX_PROCS (MAX_PROCS),
    .TIME_BITS (TIME_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_data_i      (cfg_data_i),
    .arrival_time_i  (in_i.arrival_time),
    .burst_time_i    (in_i.burst_time),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .slot_time_o     (out_o.slot_time),
    .running_id_o    (out_o.running_id),
    .idle_o          (out_o.idle),
    .segment_start_o (out_o.segment_start),
    .finished_o      (out_o.finished),
    .turnaround_o    (out_o.turnaround),
    .waiting_o       (out_o.waiting),
    .all_done_o      (out_o.all_done),
    .load_error_o    (out_o.load_error)
  );

endmodule

FILE: src/srtf_sva.sv
`timescale 1ns / 1ps
module srtf_sva
  import srtf_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid,
  input logic              out_ready,
  input logic [SLOT_W-1:0] slot_time,
  input logic [ID_W-1:0]   running_id,
  input logic              idle,
  input logic              segment_start,
  input logic              finished,
  input logic [SLOT_W-1:0] turnaround,
  input logic [SLOT_W-1:0] waiting,
  input logic              all_done,
  input logic              load_error
);

  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_idle_no_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && idle |-> (running_id == '0) && !finished)
    else $error("idle slot reports a running process");

  a_times_only_on_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !finished |-> (turnaround == '0) && (waiting == '0))
    else $error("times reported without completion");

  a_load_error_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && load_error |-> (slot_time == '0) && !idle && !segment_start && !all_done)
    else $error("load error with tick fields set");

  a_wait_le_tat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && finished |-> waiting <= turnaround)
    else $error("waiting exceeds turnaround");

endmodule

bind srtf_scheduler_core srtf_sva u_srtf_sva (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid     (out_o.valid),
  .out_ready     (out_o.ready),
  .slot_time     (out_o.slot_time),
  .running_id    (out_o.running_id),
  .idle          (out_o.idle),
  .segment_start (out_o.segment_start),
  .finished      (out_o.finished),
  .turnaround    (out_o.turnaround),
  .waiting       (out_o.waiting),
  .all_done      (out_o.all_done),
  .load_error    (out_o.load_error)
);
